// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GDSD_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GDSD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/gdsd_pkg.sv
package gdsd_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int SER_W   = 22;
  localparam int DOY_W   = 9;
  localparam int YOE_W   = 9;
  localparam int ERA_W   = 6;
  localparam int Q100_W  = 8;
  localparam int STAGES  = 4;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [COUNT_W-1:0] MAX_COUNT = 22'd3652059;

  // ceil(2^21/100) == ceil(2^23/400), exact for any 14-bit year
  localparam int RECIP_W = 15;
  localparam logic [RECIP_W-1:0] RECIP_100 = 15'd20972;
  localparam int Q100_SH = 21;
  localparam int ERA_SH  = 23;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_MAY = 4'd5;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_JUL = 4'd7;
  localparam logic [MON_W-1:0] MON_AUG = 4'd8;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_OCT = 4'd10;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // one enable per pipeline register stage of the date unit
  typedef logic [STAGES-1:0] stage_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB:                            len = leap ? 5'd29 : 5'd28;
      default:                            len = 5'd31;
    endcase
    return len;
  endfunction

  // day of year at the first of the month, year counted from march
  function automatic logic [DOY_W-1:0] march_doy(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] doy;
    case (m)
      MON_MAR: doy = 9'd0;
      MON_APR: doy = 9'd31;
      MON_MAY: doy = 9'd61;
      MON_JUN: doy = 9'd92;
      MON_JUL: doy = 9'd122;
      MON_AUG: doy = 9'd153;
      MON_SEP: doy = 9'd184;
      MON_OCT: doy = 9'd214;
      MON_NOV: doy = 9'd245;
      MON_DEC: doy = 9'd275;
      MON_JAN: doy = 9'd306;
      MON_FEB: doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

// File: sv/gdsd_date_serial.sv
module gdsd_date_serial (
  input  logic                          clk,
  input  gdsd_pkg::stage_en_t           en,
  input  logic [gdsd_pkg::DAY_W-1:0]    day,
  input  logic [gdsd_pkg::MON_W-1:0]    month,
  input  logic [gdsd_pkg::YEAR_W-1:0]   year,
  output logic [gdsd_pkg::SER_W-1:0]    serial,
  output logic                          ok
);
  import gdsd_pkg::*;

  // stage 1: reciprocal multiplies for year/100 and era
  logic [YEAR_W-1:0]         yy_nxt;
  logic [YEAR_W+RECIP_W-1:0] prod_y;
  logic [YEAR_W+RECIP_W-1:0] prod_yy;
  logic [DAY_W-1:0]          day_s1_r;
  logic [MON_W-1:0]          mon_s1_r;
  logic [YEAR_W-1:0]         year_s1_r;
  logic [YEAR_W-1:0]         yy_s1_r;
  logic [Q100_W-1:0]         q100_s1_r;
  logic [ERA_W-1:0]          era_s1_r;

  assign yy_nxt  = (month <= MON_FEB) ? year - YEAR_W'(1) : year;
  assign prod_y  = (YEAR_W+RECIP_W)'(year)   * (YEAR_W+RECIP_W)'(RECIP_100);
  assign prod_yy = (YEAR_W+RECIP_W)'(yy_nxt) * (YEAR_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      day_s1_r  <= day;
      mon_s1_r  <= month;
      year_s1_r <= year;
      yy_s1_r   <= yy_nxt;
      q100_s1_r <= prod_y[Q100_SH +: Q100_W];
      era_s1_r  <= prod_yy[ERA_SH +: ERA_W];
    end
  end

  // stage 2: leap rule, validity, year of era, day of year
  logic [YEAR_W:0]    hund;
  logic [YEAR_W:0]    era400;
  logic [YEAR_W:0]    yoe_full;
  logic               mod100z;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               ok_nxt;
  logic [DOY_W-1:0]   doy_nxt;
  logic               ok_s2_r;
  logic [YOE_W-1:0]   yoe_s2_r;
  logic [DOY_W-1:0]   doy_s2_r;
  logic [ERA_W-1:0]   era_s2_r;

  assign hund     = (YEAR_W+1)'(q100_s1_r) * (YEAR_W+1)'(100);
  assign mod100z  = ({1'b0, year_s1_r} == hund);
  assign leap     = (year_s1_r[1:0] == 2'b00) &&
                    (!mod100z || (q100_s1_r[1:0] == 2'b00));
  assign mlen     = month_len(mon_s1_r, leap);
  assign ok_nxt   = (year_s1_r != '0) && (year_s1_r <= MAX_YEAR) &&
                    (mon_s1_r >= MON_JAN) && (mon_s1_r <= MON_DEC) &&
                    (day_s1_r != '0) && (day_s1_r <= mlen);
  assign era400   = (YEAR_W+1)'(era_s1_r) * (YEAR_W+1)'(400);
  assign yoe_full = {1'b0, yy_s1_r} - era400;
  assign doy_nxt  = march_doy(mon_s1_r) + DOY_W'(day_s1_r) - DOY_W'(1);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok_s2_r  <= ok_nxt;
      yoe_s2_r <= yoe_full[YOE_W-1:0];
      doy_s2_r <= doy_nxt;
      era_s2_r <= era_s1_r;
    end
  end

  // stage 3: constant multiplies of the era and year of era
  localparam int Y365_W = 18;
  localparam int YQ_W   = 3;
  localparam int YQP_W  = 15;
  logic [Y365_W-1:0] yoe365_nxt;
  logic [YQP_W-1:0]  yq_prod;
  logic [SER_W-1:0]  era146_nxt;
  logic [SER_W-1:0]  era146_s3_r;
  logic [Y365_W-1:0] yoe365_s3_r;
  logic [YOE_W-3:0]  yoe4_s3_r;
  logic [YQ_W-1:0]   yq_s3_r;
  logic [DOY_W-1:0]  doy_s3_r;
  logic              ok_s3_r;

  assign yoe365_nxt = Y365_W'(yoe_s2_r) * Y365_W'(365);
  assign yq_prod    = YQP_W'(yoe_s2_r) * YQP_W'(41);
  assign era146_nxt = SER_W'(era_s2_r) * SER_W'(146097);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      era146_s3_r <= era146_nxt;
      yoe365_s3_r <= yoe365_nxt;
      yoe4_s3_r   <= yoe_s2_r[YOE_W-1:2];
      yq_s3_r     <= yq_prod[12 +: YQ_W];
      doy_s3_r    <= doy_s2_r;
      ok_s3_r     <= ok_s2_r;
    end
  end

  // stage 4: sum into the serial day number
  logic [SER_W-1:0] serial_nxt;
  logic [SER_W-1:0] serial_r;
  logic             ok_r;

  assign serial_nxt = era146_s3_r + SER_W'(yoe365_s3_r) + SER_W'(yoe4_s3_r)
                    - SER_W'(yq_s3_r) + SER_W'(doy_s3_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      serial_r <= serial_nxt;
      ok_r     <= ok_s3_r;
    end
  end

  assign serial = serial_r;
  assign ok     = ok_r;

endmodule

// File: sv/gregorian_date_span_days_unit.sv
// channel   handshake               beat contents
// in_       in_valid / in_ready     start day/month/year, end day/month/year, include_end
// out_      out_valid / out_ready   day_count, date_error
//
// one beat per cycle sustained when out_ready does not stall the output; the depth is set
// by the four date-unit stages plus the output register
// each stage holds its own valid bit and loads when it is empty or its successor
// loads, so a stalled output fills the bubbles behind it before in_ready drops
// rst_n (synchronous) clears all valid bits; payload registers are not reset
module gregorian_date_span_days_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gdsd_pkg::DAY_W-1:0]     in_start_day,
  input  logic [gdsd_pkg::MON_W-1:0]     in_start_month,
  input  logic [gdsd_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [gdsd_pkg::DAY_W-1:0]     in_end_day,
  input  logic [gdsd_pkg::MON_W-1:0]     in_end_month,
  input  logic [gdsd_pkg::YEAR_W-1:0]    in_end_year,
  input  logic                           in_include_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gdsd_pkg::COUNT_W-1:0]   out_day_count,
  output logic                           out_date_error
);
  import gdsd_pkg::*;

  // pipeline control: valid bits and per-stage load enables
  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] inc_r;
  stage_en_t         en;
  logic              out_en;
  logic              out_valid_r;

  always_comb begin
    out_en         = !out_valid_r || out_ready;
    en[STAGES-1]   = !valid_r[STAGES-1] || out_en;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
      if (out_en) begin
        out_valid_r <= valid_r[STAGES-1];
      end
    end
  end

  // include_end rides alongside the date pipeline
  always_ff @(posedge clk) begin
    if (en[0]) begin
      inc_r[0] <= in_include_end;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) begin
        inc_r[i] <= inc_r[i-1];
      end
    end
  end

  // one serial day number unit per date
  logic [SER_W-1:0] ser_s;
  logic [SER_W-1:0] ser_e;
  logic             ok_s;
  logic             ok_e;

  gdsd_date_serial u_start (
    .clk    (clk),
    .en     (en),
    .day    (in_start_day),
    .month  (in_start_month),
    .year   (in_start_year),
    .serial (ser_s),
    .ok     (ok_s)
  );

  gdsd_date_serial u_end (
    .clk    (clk),
    .en     (en),
    .day    (in_end_day),
    .month  (in_end_month),
    .year   (in_end_year),
    .serial (ser_e),
    .ok     (ok_e)
  );

  // output stage: difference, clamp at zero, add the end day when asked
  logic               all_ok;
  logic [COUNT_W-1:0] span;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] count_r;
  logic               err_r;

  assign all_ok    = ok_s && ok_e;
  assign span      = (ser_e > ser_s) ? COUNT_W'(ser_e - ser_s) : '0;
  // an invalid date forces a zero count whatever include_end says
  assign count_nxt = all_ok ? span + COUNT_W'(inc_r[STAGES-1]) : '0;

  always_ff @(posedge clk) begin
    if (out_en) begin
      count_r <= count_nxt;
      err_r   <= !all_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_day_count  = count_r;
  assign out_date_error = err_r;

endmodule

// File: sv/gdsd_checker.sv
`include "assert_macros.svh"

module gdsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gdsd_pkg::COUNT_W-1:0]   out_day_count,
  input logic                           out_date_error
);
  import gdsd_pkg::*;

  // a stalled result beat holds
  `GDSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_day_count) && $stable(out_date_error),
    "result beat changed while stalled")

  // a bad date gives a zero count
  `GDSD_ASSERT_IMPL(a_err_zero, out_valid && out_date_error, out_day_count == '0,
    "nonzero count with date error")

  // no span can exceed the calendar range
  `GDSD_ASSERT_IMPL(a_count_max, out_valid, out_day_count <= MAX_COUNT,
    "count beyond calendar range")

  // with no result pending the pipe always takes a beat
  `GDSD_ASSERT_IMPL(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind gregorian_date_span_days_unit gdsd_checker u_gdsd_checker (.*);

// File: verif/span_checker.sv
`timescale 1ns / 100ps

module span_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [gdsd_pkg::DAY_W-1:0]   in_start_day,
  input  logic [gdsd_pkg::MON_W-1:0]   in_start_month,
  input  logic [gdsd_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [gdsd_pkg::DAY_W-1:0]   in_end_day,
  input  logic [gdsd_pkg::MON_W-1:0]   in_end_month,
  input  logic [gdsd_pkg::YEAR_W-1:0]  in_end_year,
  input  logic                         in_include_end,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [gdsd_pkg::COUNT_W-1:0] out_day_count,
  input  logic                         out_date_error,
  output int                           fail_count,
  output int                           spans_pending,
  output int                           spans_checked,
  output int                           spans_flagged
);
  import gdsd_pkg::*;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               bad_date;
  } span_t;

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  span_t spans_due[$];

  initial begin
    fail_count    = 0;
    spans_pending = 0;
    spans_checked = 0;
    spans_flagged = 0;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input logic [MON_W-1:0] m,
                                                input logic [YEAR_W-1:0] y);
    int unsigned len;
    len = MONTH_LEN[m - MON_JAN];
    if (m == MON_FEB && is_leap(y)) len = len + 1;
    return len;
  endfunction

  function automatic bit date_valid(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                    input logic [YEAR_W-1:0] y);
    if (y < 1 || y > MAX_YEAR) return 0;
    if (m < MON_JAN || m > MON_DEC) return 0;
    return (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  // days since the start of year 1, counting the given day
  function automatic int unsigned days_since_epoch(input logic [DAY_W-1:0] d,
                                                   input logic [MON_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
    int unsigned past;
    int unsigned total;
    past  = y - 1;
    total = 365 * past + past / 4 - past / 100 + past / 400 + d;
    for (int mi = MON_JAN; mi < m; mi++) total += days_in_month(mi[MON_W-1:0], y);
    return total;
  endfunction

  function automatic span_t span_between(
    input logic [DAY_W-1:0] sd, input logic [MON_W-1:0] sm, input logic [YEAR_W-1:0] sy,
    input logic [DAY_W-1:0] ed, input logic [MON_W-1:0] em, input logic [YEAR_W-1:0] ey,
    input logic inc);
    span_t       r;
    int unsigned s;
    int unsigned e;
    int unsigned n;
    r.count    = '0;
    r.bad_date = 1'b0;
    if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
      r.bad_date = 1'b1;
    end else begin
      s = days_since_epoch(sd, sm, sy);
      e = days_since_epoch(ed, em, ey);
      n = (e > s) ? e - s : 0;
      n = n + inc;
      r.count = n[COUNT_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    span_t want;
    int    errs;
    errs = 0;
    if (rst_n) begin
      if (in_valid && in_ready)
        spans_due.push_back(span_between(in_start_day, in_start_month, in_start_year,
                                         in_end_day, in_end_month, in_end_year,
                                         in_include_end));
      if (out_valid && out_ready) begin
        if (spans_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat, day_count %0d date_error %0b",
                   $time, out_day_count, out_date_error);
        end else begin
          want = spans_due.pop_front();
          if (out_day_count !== want.count) begin
            errs++;
            $display("%0t: day_count expected %0d got %0d",
                     $time, want.count, out_day_count);
          end
          if (out_date_error !== want.bad_date) begin
            errs++;
            $display("%0t: date_error expected %0b got %0b",
                     $time, want.bad_date, out_date_error);
          end
        end
        spans_checked <= spans_checked + 1;
        if (out_date_error === 1'b1) spans_flagged <= spans_flagged + 1;
      end
    end
    fail_count    <= fail_count + errs;
    spans_pending <= spans_due.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gdsd_pkg::*;

  // watchdog: cycles with no beat on either channel before giving up
  localparam int STALL_LIMIT = 4000;
  // a margin after the last pending result has been checked, before the summary
  localparam int DRAIN_CYCLES = 12;

  // month codes outside the calendar
  localparam logic [MON_W-1:0] MON_ZERO = 4'd0;
  localparam logic [MON_W-1:0] MON_13   = 4'd13;
  localparam logic [MON_W-1:0] MON_TOP  = 4'd15;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } cal_date_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [DAY_W-1:0]     in_start_day;
  logic [MON_W-1:0]     in_start_month;
  logic [YEAR_W-1:0]    in_start_year;
  logic [DAY_W-1:0]     in_end_day;
  logic [MON_W-1:0]     in_end_month;
  logic [YEAR_W-1:0]    in_end_year;
  logic                 in_include_end;
  logic                 out_valid;
  logic                 out_ready;
  logic [COUNT_W-1:0]   out_day_count;
  logic                 out_date_error;

  int fail_count;
  int spans_pending;
  int spans_checked;
  int spans_flagged;

  int pairs_sent;
  int sender_idle_pct;
  int stall_pct;
  int idle_cycles;

  // years around the leap rule and the range limits
  int unsigned century_years [14] = '{1, 4, 99, 100, 400, 1600, 1700, 1800, 1900,
                                      2000, 2100, 2400, 9600, 9999};

  gregorian_date_span_days_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .in_end_day     (in_end_day),
    .in_end_month   (in_end_month),
    .in_end_year    (in_end_year),
    .in_include_end (in_include_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_count  (out_day_count),
    .out_date_error (out_date_error)
  );

  // watches both channels, predicts every span and compares
  span_checker u_span_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .in_end_day     (in_end_day),
    .in_end_month   (in_end_month),
    .in_end_year    (in_end_year),
    .in_include_end (in_include_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_day_count  (out_day_count),
    .out_date_error (out_date_error),
    .fail_count     (fail_count),
    .spans_pending  (spans_pending),
    .spans_checked  (spans_checked),
    .spans_flagged  (spans_flagged)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_start_day    <= '0;
    in_start_month  <= '0;
    in_start_year   <= '0;
    in_end_day      <= '0;
    in_end_month    <= '0;
    in_end_year     <= '0;
    in_include_end  <= 1'b0;
    out_ready       <= 1'b0;
    stall_pct       <= 0;
    sender_idle_pct = 0;
    pairs_sent      = 0;
    idle_cycles     = 0;
  end

  // receiver side: stall at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: no beat on either channel for too long means the block hung
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still due",
               $time, idle_cycles, spans_pending);
      $display("gregorian_date_span_days_unit test failed");
      $finish;
    end else if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // month length for building legal dates
  function automatic int unsigned month_length(input logic [MON_W-1:0] m,
                                               input int unsigned y);
    case (m) inside
      MON_FEB:                            return leap_year(y) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      default:                            return 31;
    endcase
  endfunction

  function automatic cal_date_t mk(input int unsigned d, input logic [MON_W-1:0] m,
                                   input int unsigned y);
    cal_date_t r;
    r.day   = d[DAY_W-1:0];
    r.month = m;
    r.year  = y[YEAR_W-1:0];
    return r;
  endfunction

  // a quarter of the years come from the leap-rule and range-limit list
  function automatic int unsigned pick_year();
    if ($urandom_range(3) == 0) return century_years[$urandom_range(13)];
    return $urandom_range(9999, 1);
  endfunction

  function automatic cal_date_t legal_date(input int unsigned y);
    logic [MON_W-1:0] m;
    m = MON_W'($urandom_range(MON_DEC, MON_JAN));
    return mk($urandom_range(month_length(m, y), 1), m, y);
  endfunction

  // raw field values; now and then a year outside the calendar range
  function automatic cal_date_t noise_date();
    int unsigned y;
    y = ($urandom_range(19) == 0) ? $urandom_range(16383) : $urandom_range(9999, 1);
    return mk($urandom_range(31), MON_W'($urandom_range(MON_TOP)), y);
  endfunction

  // one beat on the input channel, with a random gap in front of it
  task automatic send_pair(input cal_date_t s, input cal_date_t e, input bit inc);
    int gap;
    gap = 0;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_day   <= s.day;
    in_start_month <= s.month;
    in_start_year  <= s.year;
    in_end_day     <= e.day;
    in_end_month   <= e.month;
    in_end_year    <= e.year;
    in_include_end <= inc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  // mostly legal date pairs, close together or far apart, plus some junk
  task automatic random_pairs(input int n, input int idle_pct, input int stall);
    cal_date_t   s;
    cal_date_t   e;
    int unsigned y;
    sender_idle_pct = idle_pct;
    stall_pct      <= stall;
    repeat (n) begin
      if ($urandom_range(99) < 12) begin
        s = noise_date();
        e = $urandom_range(1) ? noise_date() : legal_date(pick_year());
        if ($urandom_range(1)) begin
          y = 32'(e.year);
          e = s;
          s = legal_date((y >= 1 && y <= 9999) ? y : 2000);
        end
      end else begin
        s = legal_date(pick_year());
        case ($urandom_range(3))
          0: e = s;
          1: e = legal_date(s.year);
          2: begin
            y = s.year + $urandom_range(3);
            e = legal_date((y > 9999) ? 9999 : y);
          end
          default: e = legal_date(pick_year());
        endcase
      end
      send_pair(s, e, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats, no idling
    // whole calendar range, both ways of counting the end day
    send_pair(mk(1, MON_JAN, 1), mk(31, MON_DEC, 9999), 1'b0);
    send_pair(mk(1, MON_JAN, 1), mk(31, MON_DEC, 9999), 1'b1);
    // same day, and end before start
    send_pair(mk(15, MON_JUN, 2020), mk(15, MON_JUN, 2020), 1'b0);
    send_pair(mk(15, MON_JUN, 2020), mk(15, MON_JUN, 2020), 1'b1);
    send_pair(mk(31, MON_DEC, 9999), mk(1, MON_JAN, 1), 1'b0);
    send_pair(mk(2, MON_MAR, 2024), mk(1, MON_MAR, 2024), 1'b1);
    // february 29 across the leap rule
    send_pair(mk(28, MON_FEB, 2024), mk(1, MON_MAR, 2024), 1'b0);
    send_pair(mk(29, MON_FEB, 2000), mk(1, MON_MAR, 2000), 1'b0);
    send_pair(mk(1, MON_JAN, 1900), mk(29, MON_FEB, 1900), 1'b0);
    send_pair(mk(29, MON_FEB, 2023), mk(1, MON_MAR, 2023), 1'b1);
    send_pair(mk(28, MON_FEB, 2100), mk(1, MON_MAR, 2100), 1'b1);
    send_pair(mk(31, MON_DEC, 1999), mk(1, MON_JAN, 2000), 1'b0);
    // day numbers at zero, past month end and at the top of the field
    send_pair(mk(0, MON_JAN, 2000), mk(1, MON_FEB, 2000), 1'b1);
    send_pair(mk(1, MON_JAN, 2000), mk(31, MON_APR, 2000), 1'b0);
    send_pair(mk(31, MON_JAN, 2000), mk(31, MON_JUL, 2000), 1'b1);
    send_pair(mk(1, MON_JAN, 2000), mk(31, MON_SEP, 2000), 1'b1);
    // bad months
    send_pair(mk(1, MON_ZERO, 2000), mk(1, MON_JAN, 2001), 1'b1);
    send_pair(mk(1, MON_JAN, 2000), mk(1, MON_13, 2001), 1'b0);
    send_pair(mk(31, MON_TOP, 9999), mk(31, MON_TOP, 9999), 1'b1);
    // years outside the calendar range
    send_pair(mk(1, MON_JAN, 0), mk(1, MON_JAN, 2000), 1'b1);
    send_pair(mk(1, MON_JAN, 2000), mk(1, MON_JAN, 10000), 1'b0);
    send_pair(mk(31, MON_DEC, 16383), mk(1, MON_JAN, 1), 1'b1);

    // random beats through the idling phases
    random_pairs(350, 0, 0);
    random_pairs(350, 65, 0);
    random_pairs(350, 0, 65);
    random_pairs(350, 10, 10);

    in_valid <= 1'b0;
    @(posedge clk);
    while (spans_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d date pairs sent, %0d spans checked, %0d of them flagged as bad dates",
             pairs_sent, spans_checked, spans_flagged);
    $display("phases: directed, free flow, sender gaps, receiver stalls, light mix");
    if (fail_count == 0 && spans_pending == 0) begin
      $display("gregorian_date_span_days_unit test passed");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived",
               $time, fail_count, spans_pending);
      $display("gregorian_date_span_days_unit test failed");
    end
    $finish;
  end

endmodule
